[rtl/core/wps_pkg.sv]
// shared widths, constants and register codes for the wheel pulse speedometer
// used by wps_div1k and wheel_pulse_speedometer_top, depends on nothing
`timescale 1ns / 1ps

package wps_pkg;

    localparam int TIME_BITS  = 48;
    localparam int COUNT_BITS = 32;

    localparam int MM_BITS      = 12;
    localparam int MIN_BITS     = 10;
    localparam int TOUT_BITS    = 16;
    localparam int SPD_BITS     = 22;
    localparam int DIST_BITS    = 34;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    // microseconds per millisecond, also millimetres per metre scale
    localparam int MS_DIV   = 1000;
    localparam int REM_BITS = 10;

    localparam int PROD_BITS = COUNT_BITS + MM_BITS;
    localparam int DIV_BITS  = (TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS;

    localparam int IN_TDATA_BITS  = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = SPD_BITS + DIST_BITS + 2;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [SPD_BITS-1:0]      SPEED_MAX  = '1;
    localparam logic [MM_BITS-1:0]       MM_RESET   = MM_BITS'(2100);
    localparam logic [MIN_BITS-1:0]      MIN_RESET  = MIN_BITS'(50);
    localparam logic [TOUT_BITS-1:0]     TOUT_RESET = TOUT_BITS'(3000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WHEEL_MM     = 2'd0,
        CFG_MIN_INTERVAL = 2'd1,
        CFG_TIMEOUT      = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FUNC_PULSE = 1'b0,
        FUNC_READ  = 1'b1
    } func_t;

endpackage

[rtl/core/wps_div1k.sv]
// bit-serial restoring divider by the constant 1000, one quotient bit per cycle
// depends on wps_pkg
`timescale 1ns / 1ps

module wps_div1k
    import wps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] num,
    output logic                busy,
    output logic [DIV_BITS-1:0] quo,
    output logic [REM_BITS-1:0] rem
);

    localparam int CNT_BITS = $clog2(DIV_BITS);

    logic [DIV_BITS-1:0] acc_reg;
    logic [REM_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;

    logic [REM_BITS:0]   trial;
    logic                ge;
    logic [REM_BITS:0]   diff;
    logic [REM_BITS-1:0] rem_next;

    assign trial    = {rem_reg, acc_reg[DIV_BITS-1]};
    assign ge       = (trial >= (REM_BITS+1)'(MS_DIV));
    assign diff     = trial - (REM_BITS+1)'(MS_DIV);
    assign rem_next = ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            acc_reg  <= num;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            acc_reg <= {acc_reg[DIV_BITS-2:0], ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(DIV_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = acc_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/wheel_pulse_speedometer_top.sv]
// wheel speed and distance from timestamped pulses, top level
// depends on wps_pkg and wps_div1k
//
//  channel   direction  beat fields
//  s_axis    in         tuser: func, tdata: now_us
//  m_axis    out        tdata: speed_mm_s, distance_m, pulse_accepted, timed_out
//  cfg       in         cfg_index, cfg_data (wheel_mm, min_interval_ms, timeout_ms)
//
// one item at a time: an accept step, the two serial /1000 dividers (gap in ms
// and distance run side by side until both finish), a decide step, speed
// division for an accepted nonzero-gap pulse, then a step to load the output
// register. a finished result waits in the output register while the next item
// is taken; the next result then stalls in the output step until that register
// drains. rst_n returns all state to its reset values at once; cfg is always ready.
`timescale 1ns / 1ps

module wheel_pulse_speedometer_top
    import wps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [47:0] now_us
    input  logic                      s_tuser,   // [0] func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [21:0] speed_mm_s, [55:22] distance_m,
                                                 // [56] pulse_accepted, [57] timed_out
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SCNT_BITS = $clog2(SPD_BITS);
    localparam int PAD_BITS  = OUT_TDATA_BITS - OUT_FIELD_BITS;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TDIV   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_SDIV   = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [MM_BITS-1:0]    wheel_mm_reg;
    logic [MIN_BITS-1:0]   min_interval_reg;
    logic [TOUT_BITS-1:0]  timeout_reg;

    logic [TIME_BITS-1:0]  last_pulse_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [SPD_BITS-1:0]   speed_value_reg;

    logic                  func_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  fwd_reg;
    logic                  acc_reg;
    logic                  tout_reg;
    logic [DIST_BITS-1:0]  dist_reg;

    logic [SPD_BITS-1:0]   snum_reg;
    logic [SPD_BITS-1:0]   srem_reg;
    logic [SCNT_BITS-1:0]  scnt_reg;

    logic                      m_tvalid_reg;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg;

    logic                  in_beat;
    logic [TIME_BITS-1:0]  now_in;
    logic [TIME_BITS-1:0]  diff_us;
    logic [PROD_BITS-1:0]  prod;
    logic                  busy_t, busy_d;
    logic [DIV_BITS-1:0]   gap_ms, quo_d;
    logic [REM_BITS-1:0]   rem_t, rem_d;

    logic                  take;
    logic                  late;
    logic                  gap_zero;
    logic [MM_BITS:0]      dsum;
    logic [2:0]            dadj;
    logic [DIST_BITS-1:0]  dist_base;
    logic [DIST_BITS-1:0]  dist_inc;

    logic                  gap_big;
    logic [SPD_BITS:0]     strial;
    logic                  sge;
    logic [SPD_BITS:0]     sdiff;
    logic [SPD_BITS-1:0]   srem_next;
    logic [SPD_BITS-1:0]   snum_next;
    logic [SPD_BITS-1:0]   speed_out;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mm_reg     <= MM_RESET;
            min_interval_reg <= MIN_RESET;
            timeout_reg      <= TOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WHEEL_MM:     wheel_mm_reg     <= cfg_data[MM_BITS-1:0];
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data[MIN_BITS-1:0];
                CFG_TIMEOUT:      timeout_reg      <= cfg_data[TOUT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- input side and serial dividers ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign now_in   = s_tdata[TIME_BITS-1:0];
    assign diff_us  = now_in - last_pulse_reg;
    assign prod     = PROD_BITS'(count_reg) * PROD_BITS'(wheel_mm_reg);

    wps_div1k u_gap_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_beat),
        .num   (DIV_BITS'(diff_us)),
        .busy  (busy_t),
        .quo   (gap_ms),
        .rem   (rem_t)
    );

    // distance for the old count; the decide step adds one more wheel if needed
    wps_div1k u_dist_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_beat),
        .num   (DIV_BITS'(prod)),
        .busy  (busy_d),
        .quo   (quo_d),
        .rem   (rem_d)
    );

    // ---------------- decide ----------------
    assign gap_zero = (gap_ms == '0);
    assign take     = (func_reg == FUNC_PULSE) && fwd_reg
                      && (gap_ms >= DIV_BITS'(min_interval_reg));
    // an accepted pulse restarts the gap, so it never times out
    assign late     = !take && fwd_reg && (gap_ms > DIV_BITS'(timeout_reg));

    // floor((count+1)*mm/1000) = q + floor((r + mm)/1000), r + mm below 5096
    assign dsum = (MM_BITS+1)'(rem_t & '0) + (MM_BITS+1)'(rem_d) + (MM_BITS+1)'(wheel_mm_reg);

    always_comb
    begin
        if (dsum >= (MM_BITS+1)'(5 * MS_DIV))
            dadj = 3'd5;
        else if (dsum >= (MM_BITS+1)'(4 * MS_DIV))
            dadj = 3'd4;
        else if (dsum >= (MM_BITS+1)'(3 * MS_DIV))
            dadj = 3'd3;
        else if (dsum >= (MM_BITS+1)'(2 * MS_DIV))
            dadj = 3'd2;
        else if (dsum >= (MM_BITS+1)'(MS_DIV))
            dadj = 3'd1;
        else
            dadj = 3'd0;
    end

    assign dist_base = DIST_BITS'(quo_d);
    assign dist_inc  = dist_base + DIST_BITS'(dadj);

    // ---------------- speed division, one bit a cycle ----------------
    assign gap_big   = |gap_ms[DIV_BITS-1:SPD_BITS+1];
    assign strial    = {srem_reg, snum_reg[SPD_BITS-1]};
    assign sge       = !gap_big && (strial >= gap_ms[SPD_BITS:0]);
    assign sdiff     = strial - gap_ms[SPD_BITS:0];
    assign srem_next = sge ? sdiff[SPD_BITS-1:0] : strial[SPD_BITS-1:0];
    assign snum_next = {snum_reg[SPD_BITS-2:0], sge};

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (!busy_t && !busy_d)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (take && !gap_zero)
                    state_next = ST_SDIV;
                else
                    state_next = ST_OUT;
            end
            ST_SDIV:
            begin
                if (scnt_reg == SCNT_BITS'(SPD_BITS - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign speed_out = tout_reg ? '0 : speed_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_pulse_reg  <= '0;
            count_reg       <= '0;
            speed_value_reg <= '0;
            func_reg        <= FUNC_PULSE;
            now_reg         <= '0;
            fwd_reg         <= 1'b0;
            acc_reg         <= 1'b0;
            tout_reg        <= 1'b0;
            dist_reg        <= '0;
            snum_reg        <= '0;
            srem_reg        <= '0;
            scnt_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        func_reg <= s_tuser;
                        now_reg  <= now_in;
                        fwd_reg  <= (now_in >= last_pulse_reg);
                    end
                end
                ST_TDIV:
                begin
                end
                ST_DECIDE:
                begin
                    acc_reg  <= take;
                    tout_reg <= late;
                    // a count wrapping to zero reads zero distance
                    if (take)
                        dist_reg <= (&count_reg) ? '0 : dist_inc;
                    else
                        dist_reg <= dist_base;
                    if (take)
                    begin
                        count_reg      <= count_reg + 1'b1;
                        last_pulse_reg <= now_reg;
                        if (gap_zero)
                            speed_value_reg <= SPEED_MAX;
                    end
                    snum_reg <= SPD_BITS'(SPD_BITS'(wheel_mm_reg) * SPD_BITS'(MS_DIV));
                    srem_reg <= '0;
                    scnt_reg <= '0;
                end
                ST_SDIV:
                begin
                    snum_reg <= snum_next;
                    srem_reg <= srem_next;
                    scnt_reg <= scnt_reg + 1'b1;
                    if (scnt_reg == SCNT_BITS'(SPD_BITS - 1))
                        speed_value_reg <= snum_next;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {{PAD_BITS{1'b0}}, tout_reg, acc_reg,
                                         dist_reg, speed_out};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
